/* sv/sllb_pkg.sv */
package sllb_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_ATTACK  = 3'd0;
    localparam logic [2:0] REG_RELEASE = 3'd1;
    localparam logic [2:0] REG_HOLD    = 3'd2;
    localparam logic [2:0] REG_DECAY   = 3'd3;
    localparam logic [2:0] REG_FLOOR   = 3'd4;
    localparam logic [2:0] REG_YELLOW  = 3'd5;
    localparam logic [2:0] REG_RED     = 3'd6;

    // zone codes
    localparam logic [1:0] ZONE_OFF    = 2'd0;
    localparam logic [1:0] ZONE_GREEN  = 2'd1;
    localparam logic [1:0] ZONE_YELLOW = 2'd2;
    localparam logic [1:0] ZONE_RED    = 2'd3;

    localparam logic [16:0] FULL_SCALE = 17'd32768;
    localparam logic [16:0] PEAK_SHOW  = 17'd327;
    localparam logic [16:0] ROUND_HALF = 17'd32768;

    localparam logic [15:0] RST_ATTACK  = 16'd39322;
    localparam logic [15:0] RST_RELEASE = 16'd9830;
    localparam logic [7:0]  RST_HOLD    = 8'd30;
    localparam logic [15:0] RST_DECAY   = 16'd62259;
    localparam logic [15:0] RST_FLOOR   = 16'd164;
    localparam logic [15:0] RST_YELLOW  = 16'd24576;
    localparam logic [15:0] RST_RED     = 16'd29491;

    typedef struct packed {
        logic [15:0] attack_coeff;
        logic [15:0] release_coeff;
        logic [7:0]  hold_ticks;
        logic [15:0] decay_factor;
        logic [15:0] peak_floor;
        logic [15:0] yellow_threshold;
        logic [15:0] red_threshold;
    } cfg_t;

    // pipeline advance strobes from the top level to the lanes
    typedef struct packed {
        logic accept;   // input transfer: update smoothed level
        logic adv2;     // stage 1 moves into the peak stage
    } lane_ctrl_t;

    // c is already clamped to 0..32768
    function automatic logic [1:0] zone_of(input logic [16:0] c, input cfg_t cfg);
        logic [1:0] z;
        if (c > {1'b0, cfg.red_threshold})
        begin
            z = ZONE_RED;
        end
        else if (c > {1'b0, cfg.yellow_threshold})
        begin
            z = ZONE_YELLOW;
        end
        else
        begin
            z = ZONE_GREEN;
        end
        return z;
    endfunction

endpackage

/* sv/stereo_level_meter_ballistics.sv */
// Stereo peak meter with attack/release smoothing and peak hold. One meter tick
// is accepted per clock cycle unless the input stalls. A tick passes three
// registers (smoothing stage, peak stage, output register) before its result
// can transfer. The cycle budget is set by the per-channel smoothing
// recurrence, one Q0.16 multiply and add per tick, and the peak recurrence, one
// decay multiply per tick, each in its own stage. Back pressure reaches
// s_tready combinationally from m_tready. Input stalls only when all three
// stages are full and the output is not taken. The left and right channels
// run in two identical lanes; the output stage forms zone codes and saturates
// levels to 16 bits. Registers are written through cfg_we/cfg_addr/cfg_data;
// the user must write them only while the block is idle, which it does not enforce.
module stereo_level_meter_ballistics #(
    parameter int LEVEL_BITS = 16,
    parameter int HOLD_BITS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // left_in[15:0], right_in[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    // smooth_left, smooth_right, hold_left, hold_right (16 each),
    // zone_left, zone_right, peak_zone_left, peak_zone_right (2 each)
    output logic [71:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    sllb_pkg::cfg_t       cfg_reg;
    sllb_pkg::lane_ctrl_t ctrl;
    logic                 v1_reg, v2_reg;
    logic                 take, en2, en1;
    logic [LEVEL_BITS-1:0] smooth_l, smooth_r, peak_l, peak_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_coeff     <= sllb_pkg::RST_ATTACK;
            cfg_reg.release_coeff    <= sllb_pkg::RST_RELEASE;
            cfg_reg.hold_ticks       <= sllb_pkg::RST_HOLD;
            cfg_reg.decay_factor     <= sllb_pkg::RST_DECAY;
            cfg_reg.peak_floor       <= sllb_pkg::RST_FLOOR;
            cfg_reg.yellow_threshold <= sllb_pkg::RST_YELLOW;
            cfg_reg.red_threshold    <= sllb_pkg::RST_RED;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                sllb_pkg::REG_ATTACK:  cfg_reg.attack_coeff     <= cfg_data;
                sllb_pkg::REG_RELEASE: cfg_reg.release_coeff    <= cfg_data;
                sllb_pkg::REG_HOLD:    cfg_reg.hold_ticks       <= cfg_data[7:0];
                sllb_pkg::REG_DECAY:   cfg_reg.decay_factor     <= cfg_data;
                sllb_pkg::REG_FLOOR:   cfg_reg.peak_floor       <= cfg_data;
                sllb_pkg::REG_YELLOW:  cfg_reg.yellow_threshold <= cfg_data;
                sllb_pkg::REG_RED:     cfg_reg.red_threshold    <= cfg_data;
                default:               ;
            endcase
        end
    end

    // each stage advances when the one after it is empty or moving
    assign en2      = !v2_reg || take;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    assign ctrl.accept = s_tvalid && en1;
    assign ctrl.adv2   = v1_reg && en2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    sllb_lane #(
        .LEVEL_BITS (LEVEL_BITS),
        .HOLD_BITS  (HOLD_BITS)
    ) u_lane_l (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .ctrl       (ctrl),
        .level_in   (s_tdata[15:0]),
        .smooth_out (smooth_l),
        .peak_out   (peak_l)
    );

    sllb_lane #(
        .LEVEL_BITS (LEVEL_BITS),
        .HOLD_BITS  (HOLD_BITS)
    ) u_lane_r (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .ctrl       (ctrl),
        .level_in   (s_tdata[31:16]),
        .smooth_out (smooth_r),
        .peak_out   (peak_r)
    );

    sllb_merge #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (v2_reg),
        .take     (take),
        .smooth_l (smooth_l),
        .smooth_r (smooth_r),
        .peak_l   (peak_l),
        .peak_r   (peak_r),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted tick did not enter the smoothing stage");

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !en2 |=> v1_reg)
        else $error("stalled smoothing stage lost its tick");

    a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !(v1_reg && v2_reg && m_tvalid && !m_tready))
        else $error("ready raised with a full, stalled pipeline");

    a_peak_moves_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !take |=> v2_reg)
        else $error("stalled peak stage lost its tick");

endmodule

/* sv/sllb_lane.sv */
module sllb_lane #(
    parameter int LEVEL_BITS = 16,
    parameter int HOLD_BITS  = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sllb_pkg::cfg_t            cfg,
    input  sllb_pkg::lane_ctrl_t      ctrl,
    input  logic [15:0]               level_in,
    output logic [LEVEL_BITS-1:0]     smooth_out,
    output logic [LEVEL_BITS-1:0]     peak_out
);

    localparam int LB = LEVEL_BITS;
    localparam int IW = (LB > 16) ? LB : 16;
    localparam int HW = (HOLD_BITS > 8) ? HOLD_BITS : 8;

    logic [LB-1:0]        smoothed_reg, smoothed_next;
    logic [LB-1:0]        smooth2_reg;
    logic [LB-1:0]        peak_reg, peak_next;
    logic [HOLD_BITS-1:0] count_reg, count_next;

    logic [IW-1:0]        in_w, lmax_w;
    logic [LB-1:0]        target, gap, step;
    logic [15:0]          coeff;
    logic                 rising;
    logic [LB+15:0]       prod;
    logic [LB+16:0]       rnd;
    logic [LB+15:0]       decay_prod;
    logic [LB-1:0]        decayed;
    logic [IW-1:0]        decayed_w, floor_w;
    logic [HW-1:0]        hold_w, hmax_w;
    logic [HOLD_BITS-1:0] hold_load;

    // stage 1: smoothed level
    always_comb
    begin
        in_w   = IW'(level_in);
        lmax_w = IW'({LB{1'b1}});
        target = (in_w > lmax_w) ? LB'(lmax_w) : LB'(in_w);
        rising = target > smoothed_reg;
        gap    = rising ? (target - smoothed_reg) : (smoothed_reg - target);
        coeff  = rising ? cfg.attack_coeff : cfg.release_coeff;
        prod   = (LB+16)'(gap) * (LB+16)'(coeff);
        rnd    = {1'b0, prod} + (LB+17)'(sllb_pkg::ROUND_HALF);
        step   = rnd[LB+15:16];
        smoothed_next = rising ? (smoothed_reg + step) : (smoothed_reg - step);
    end

    // stage 2: peak hold and decay on the stage-1 level
    always_comb
    begin
        decay_prod = (LB+16)'(peak_reg) * (LB+16)'(cfg.decay_factor);
        decayed    = decay_prod[LB+15:16];
        decayed_w  = IW'(decayed);
        floor_w    = IW'(cfg.peak_floor);
        hold_w     = HW'(cfg.hold_ticks);
        hmax_w     = HW'({HOLD_BITS{1'b1}});
        hold_load  = (hold_w > hmax_w) ? HOLD_BITS'(hmax_w) : HOLD_BITS'(hold_w);
        peak_next  = peak_reg;
        count_next = count_reg;
        priority if (smoothed_reg >= peak_reg)
        begin
            peak_next  = smoothed_reg;
            count_next = hold_load;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            peak_next = (decayed_w < floor_w) ? '0 : decayed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_reg <= '0;
            peak_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (ctrl.accept)
            begin
                smoothed_reg <= smoothed_next;
            end
            if (ctrl.adv2)
            begin
                peak_reg  <= peak_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv2)
        begin
            smooth2_reg <= smoothed_reg;
        end
    end

    assign smooth_out = smooth2_reg;
    assign peak_out   = peak_reg;

endmodule

/* sv/sllb_merge.sv */
module sllb_merge #(
    parameter int LEVEL_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sllb_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  take,
    input  logic [LEVEL_BITS-1:0] smooth_l,
    input  logic [LEVEL_BITS-1:0] smooth_r,
    input  logic [LEVEL_BITS-1:0] peak_l,
    input  logic [LEVEL_BITS-1:0] peak_r,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [71:0]           m_tdata
);

    localparam int WW = (LEVEL_BITS > 17) ? LEVEL_BITS : 17;

    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg, m_tdata_next;

    function automatic logic [16:0] clamp_unit(input logic [LEVEL_BITS-1:0] v);
        logic [WW-1:0] w;
        w = WW'(v);
        return (w > WW'(sllb_pkg::FULL_SCALE)) ? sllb_pkg::FULL_SCALE : w[16:0];
    endfunction

    function automatic logic [15:0] sat16(input logic [LEVEL_BITS-1:0] v);
        logic [WW-1:0] w;
        w = WW'(v);
        return (w > WW'(17'hFFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [1:0] bar_zone(input logic [16:0] c, input sllb_pkg::cfg_t k);
        return (c == '0) ? sllb_pkg::ZONE_OFF : sllb_pkg::zone_of(c, k);
    endfunction

    function automatic logic [1:0] mark_zone(input logic [16:0] c, input sllb_pkg::cfg_t k);
        return (c <= sllb_pkg::PEAK_SHOW) ? sllb_pkg::ZONE_OFF : sllb_pkg::zone_of(c, k);
    endfunction

    always_comb
    begin
        m_tdata_next = {
            mark_zone(clamp_unit(peak_r), cfg),
            mark_zone(clamp_unit(peak_l), cfg),
            bar_zone(clamp_unit(smooth_r), cfg),
            bar_zone(clamp_unit(smooth_l), cfg),
            sat16(peak_r),
            sat16(peak_l),
            sat16(smooth_r),
            sat16(smooth_l)
        };
    end

    assign take = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (take)
        begin
            m_tvalid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_valid)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* tb/tb_stereo_level_meter_ballistics.sv */
`timescale 1ns / 1ps

module tb_stereo_level_meter_ballistics;

    // no register sits at this index
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [15:0] right;
        logic [15:0] left;
    } tick_t;

    typedef struct packed {
        logic [1:0]  peak_zone_right;
        logic [1:0]  peak_zone_left;
        logic [1:0]  zone_right;
        logic [1:0]  zone_left;
        logic [15:0] hold_right;
        logic [15:0] hold_left;
        logic [15:0] smooth_right;
        logic [15:0] smooth_left;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // left_in[15:0], right_in[31:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // smooth_left, smooth_right, hold_left, hold_right (16 each),
    // zone_left, zone_right, peak_zone_left, peak_zone_right (2 each)
    logic [71:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;

    stereo_level_meter_ballistics dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // meter state as the block should hold it, channel 0 left, 1 right
    sllb_pkg::cfg_t meter_cfg = '{sllb_pkg::RST_ATTACK, sllb_pkg::RST_RELEASE,
                                  sllb_pkg::RST_HOLD, sllb_pkg::RST_DECAY,
                                  sllb_pkg::RST_FLOOR, sllb_pkg::RST_YELLOW,
                                  sllb_pkg::RST_RED};
    logic [15:0] level_st [2] = '{16'd0, 16'd0};
    logic [15:0] peak_st  [2] = '{16'd0, 16'd0};
    logic [7:0]  count_st [2] = '{8'd0, 8'd0};

    tick_t    ticks_pending [$];
    reading_t readings_due [$];
    int       n_queued = 0;
    int       n_accepted = 0;
    int       fail_count = 0;
    logic     squeeze = 1'b0;

    function automatic logic [1:0] zone_code(logic [15:0] v, logic [16:0] hide_at);
        logic [16:0] c;
        c = ({1'b0, v} > sllb_pkg::FULL_SCALE) ? sllb_pkg::FULL_SCALE : {1'b0, v};
        if (c <= hide_at)
            return sllb_pkg::ZONE_OFF;
        if (c > {1'b0, meter_cfg.red_threshold})
            return sllb_pkg::ZONE_RED;
        if (c > {1'b0, meter_cfg.yellow_threshold})
            return sllb_pkg::ZONE_YELLOW;
        return sllb_pkg::ZONE_GREEN;
    endfunction

    function automatic void step_channel(int ch, logic [15:0] target);
        logic [32:0] glide;
        logic [31:0] decayed;
        logic [15:0] cur;
        cur = level_st[ch];
        // close a rounded fraction of the gap
        if (target > cur)
        begin
            glide = 33'(target - cur) * 33'(meter_cfg.attack_coeff) + 33'd32768;
            level_st[ch] = cur + glide[31:16];
        end
        else
        begin
            glide = 33'(cur - target) * 33'(meter_cfg.release_coeff) + 33'd32768;
            level_st[ch] = cur - glide[31:16];
        end
        if (level_st[ch] >= peak_st[ch])
        begin
            peak_st[ch]  = level_st[ch];
            count_st[ch] = meter_cfg.hold_ticks;
        end
        else if (count_st[ch] != 0)
        begin
            count_st[ch] = count_st[ch] - 8'd1;
        end
        else
        begin
            decayed = 32'(peak_st[ch]) * 32'(meter_cfg.decay_factor);
            peak_st[ch] = decayed[31:16];
            if (peak_st[ch] < meter_cfg.peak_floor)
                peak_st[ch] = '0;
        end
    endfunction

    function automatic reading_t meter_tick(tick_t t);
        reading_t r;
        step_channel(0, t.left);
        step_channel(1, t.right);
        r.smooth_left     = level_st[0];
        r.smooth_right    = level_st[1];
        r.hold_left       = peak_st[0];
        r.hold_right      = peak_st[1];
        r.zone_left       = zone_code(level_st[0], 17'd0);
        r.zone_right      = zone_code(level_st[1], 17'd0);
        r.peak_zone_left  = zone_code(peak_st[0], sllb_pkg::PEAK_SHOW);
        r.peak_zone_right = zone_code(peak_st[1], sllb_pkg::PEAK_SHOW);
        return r;
    endfunction

    // sender: bursts of transfers with random gaps, no gaps while squeezed
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                readings_due.push_back(meter_tick(s_tdata));
                n_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0 && !squeeze)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (ticks_pending.size() > 0)
                begin
                    s_tdata  <= ticks_pending.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stretches of always-ready, random and periodic stalls
    int rx_mode = 0;
    int rx_span = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_span == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                rx_span = $urandom_range(8, 80);
            end
            else
            begin
                rx_span--;
            end
            unique case (rx_mode)
                0:       m_tready <= !squeeze;
                1:       m_tready <= !squeeze && ($urandom_range(0, 1) == 1);
                default: m_tready <= !squeeze && (rx_span[1:0] != 2'd0);
            endcase
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        reading_t want;
        reading_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (readings_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("mismatch: unexpected result %h", m_tdata);
            end
            else
            begin
                want = readings_due.pop_front();
                check_field("smooth_left", want.smooth_left, got.smooth_left);
                check_field("smooth_right", want.smooth_right, got.smooth_right);
                check_field("hold_left", want.hold_left, got.hold_left);
                check_field("hold_right", want.hold_right, got.hold_right);
                check_field("zone_left", 16'(want.zone_left), 16'(got.zone_left));
                check_field("zone_right", 16'(want.zone_right), 16'(got.zone_right));
                check_field("peak_zone_left", 16'(want.peak_zone_left),
                            16'(got.peak_zone_left));
                check_field("peak_zone_right", 16'(want.peak_zone_right),
                            16'(got.peak_zone_right));
            end
        end
    end

    // hold the output side off long enough for the block to back up its input
    initial
    begin
        wait (n_accepted >= 60);
        @(posedge clk);
        squeeze <= 1'b1;
        repeat (300) @(posedge clk);
        squeeze <= 1'b0;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic queue_tick(logic [15:0] l, logic [15:0] r);
        tick_t t;
        t.left  = l;
        t.right = r;
        ticks_pending.push_back(t);
        n_queued++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        unique case (idx)
            sllb_pkg::REG_ATTACK:  meter_cfg.attack_coeff     = val;
            sllb_pkg::REG_RELEASE: meter_cfg.release_coeff    = val;
            sllb_pkg::REG_HOLD:    meter_cfg.hold_ticks       = val[7:0];
            sllb_pkg::REG_DECAY:   meter_cfg.decay_factor     = val;
            sllb_pkg::REG_FLOOR:   meter_cfg.peak_floor       = val;
            sllb_pkg::REG_YELLOW:  meter_cfg.yellow_threshold = val;
            sllb_pkg::REG_RED:     meter_cfg.red_threshold    = val;
            default:               ;
        endcase
    endtask

    task automatic setup(logic [15:0] att, logic [15:0] rel, logic [7:0] hold,
                         logic [15:0] dec, logic [15:0] flr, logic [15:0] yel,
                         logic [15:0] red);
        write_reg(sllb_pkg::REG_ATTACK, att);
        write_reg(sllb_pkg::REG_RELEASE, rel);
        write_reg(sllb_pkg::REG_HOLD, {8'd0, hold});
        write_reg(sllb_pkg::REG_DECAY, dec);
        write_reg(sllb_pkg::REG_FLOOR, flr);
        write_reg(sllb_pkg::REG_YELLOW, yel);
        write_reg(sllb_pkg::REG_RED, red);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (n_accepted != n_queued || readings_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_level();
        unique case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 400));
            1:       return 16'($urandom_range(20000, 34000));
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [15:0] pick_threshold();
        return ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    endfunction

    // envelopes held for a few ticks, left-channel silences long enough to reach decay, noise
    task automatic queue_program(int n);
        int made;
        int kind;
        int len;
        logic [15:0] l;
        logic [15:0] r;
        made = 0;
        while (made < n)
        begin
            kind = $urandom_range(0, 7);
            if (kind < 4)
            begin
                l = pick_level();
                r = pick_level();
                len = $urandom_range(1, 12);
            end
            else if (kind < 6)
            begin
                l = '0;
                r = ($urandom_range(0, 1) == 1) ? 16'd0 : pick_level();
                len = $urandom_range(5, 60);
            end
            else
            begin
                len = $urandom_range(1, 6);
            end
            repeat (len)
            begin
                if (kind >= 6)
                begin
                    l = 16'($urandom);
                    r = 16'($urandom);
                end
                queue_tick(l, r);
                made++;
            end
        end
    endtask

    initial
    begin
        logic [15:0] edges [12];
        edges = '{16'd24576, 16'd24577, 16'd29491, 16'd29492, 16'd0, 16'd327,
                  16'd328, 16'd1, 16'd32768, 16'd32769, 16'd65535, 16'd0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: full scale, overrange, alternating bit patterns
        queue_tick(16'd0, 16'd0);
        repeat (3) queue_tick(16'd32768, 16'd32768);
        queue_tick(16'd65535, 16'd0);
        queue_tick(16'd0, 16'd65535);
        queue_tick(16'hAAAA, 16'h5555);
        queue_tick(16'h5555, 16'hAAAA);
        repeat (2) queue_tick(16'd0, 16'd0);
        queue_program(100);
        wait_idle();

        // near-instant tracking so the smoothed level lands on zone edges
        setup(16'hFFFF, 16'hFFFF, 8'd0, 16'd0, 16'd0, 16'd24576, 16'd29491);
        write_reg(REG_UNUSED, 16'h1234);
        @(posedge clk);
        cfg_we <= 1'b0;
        for (int i = 0; i < 12; i++)
            queue_tick(edges[i], edges[11 - i]);
        wait_idle();

        // rise only, longest hold, thresholds beyond full scale and inverted
        setup(16'hFFFF, 16'd0, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        queue_program(20);
        wait_idle();

        // fall only, no hold, every decayed peak snaps to zero
        setup(16'd0, 16'hFFFF, 8'd0, 16'hFFFF, 16'hFFFF, 16'd30000, 16'd20000);
        queue_program(20);
        wait_idle();

        repeat (3)
        begin
            setup(16'($urandom), 16'($urandom),
                  ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 12)),
                  16'($urandom_range(30000, 65535)), 16'($urandom_range(0, 4000)),
                  pick_threshold(), pick_threshold());
            queue_program(100);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
